/* sv/rvxu_pkg.sv */
// Shared types, command codes and memory geometry for the RV32 execute unit.
package rvxu_pkg;

  // Data memory size in bytes; must be a power of two (address wraps by masking)
  localparam int MEM_BYTES = 16384;
  // Memory is split into four byte lanes, one row holds one aligned word
  localparam int MEM_ROWS  = MEM_BYTES / 4;
  localparam int BADDR_W   = $clog2(MEM_BYTES);
  localparam int ROW_W     = BADDR_W - 2;

  typedef logic [4:0] cmd_t;

  localparam cmd_t CMD_ADD   = 5'd0;
  localparam cmd_t CMD_AND   = 5'd1;
  localparam cmd_t CMD_OR    = 5'd2;
  localparam cmd_t CMD_SUB   = 5'd3;
  localparam cmd_t CMD_XOR   = 5'd4;
  localparam cmd_t CMD_ADDI  = 5'd5;
  localparam cmd_t CMD_ANDI  = 5'd6;
  localparam cmd_t CMD_ORI   = 5'd7;
  localparam cmd_t CMD_AUIPC = 5'd8;
  localparam cmd_t CMD_LUI   = 5'd9;
  localparam cmd_t CMD_BEQ   = 5'd10;
  localparam cmd_t CMD_BNE   = 5'd11;
  localparam cmd_t CMD_BGE   = 5'd12;
  localparam cmd_t CMD_BGEU  = 5'd13;
  localparam cmd_t CMD_BLT   = 5'd14;
  localparam cmd_t CMD_BLTU  = 5'd15;
  localparam cmd_t CMD_JAL   = 5'd16;
  localparam cmd_t CMD_JALR  = 5'd17;
  localparam cmd_t CMD_LB    = 5'd18;
  localparam cmd_t CMD_LBU   = 5'd19;
  localparam cmd_t CMD_LW    = 5'd20;
  localparam cmd_t CMD_SB    = 5'd21;
  localparam cmd_t CMD_SW    = 5'd22;
  localparam cmd_t CMD_SLTU  = 5'd23;
  localparam cmd_t CMD_SLT   = 5'd24;
  localparam cmd_t CMD_SLLI  = 5'd25;
  localparam cmd_t CMD_SRLI  = 5'd26;
  localparam cmd_t CMD_SRAI  = 5'd27;

  typedef logic [1:0] ld_kind_t;

  localparam ld_kind_t LD_NONE = 2'd0;
  localparam ld_kind_t LD_B    = 2'd1;
  localparam ld_kind_t LD_BU   = 2'd2;
  localparam ld_kind_t LD_W    = 2'd3;

  // Execute stage outcome carried to the memory stage
  typedef struct packed {
    logic [31:0] npc;
    logic        taken;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    ld_kind_t    ld;
  } exec_res_t;

  // Data memory access request
  typedef struct packed {
    logic               st_byte;
    logic               st_word;
    logic [BADDR_W-1:0] addr;
    logic [31:0]        data;
  } mem_req_t;

endpackage

/* sv/rvxu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rvxu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, read port returns the old contents on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/rvxu_regfile.sv */
// Register file: two read ports, one write port, per-register valid bits for reset.
module rvxu_regfile (
  input  logic        clk,
  input  logic        rst,
  input  logic        re,
  input  logic [4:0]  raddr1,
  input  logic [4:0]  raddr2,
  input  logic        we,
  input  logic [4:0]  waddr,
  input  logic [31:0] wdata,
  output logic [31:0] rdata1,
  output logic [31:0] rdata2
);

  logic [31:0] vbits;
  logic        v1;
  logic        v2;
  logic [31:0] ram1;
  logic [31:0] ram2;

  // One copy per read port, both written together
  rvxu_ram #(.WIDTH(32), .DEPTH(32)) u_bank1 (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr1),
    .rdata (ram1)
  );

  rvxu_ram #(.WIDTH(32), .DEPTH(32)) u_bank2 (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr2),
    .rdata (ram2)
  );

  // Mark written registers; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      if (we) begin
        vbits[waddr] <= 1'b1;
      end
      if (re) begin
        v1 <= vbits[raddr1];
        v2 <= vbits[raddr2];
      end
    end
  end

  assign rdata1 = v1 ? ram1 : 32'd0;
  assign rdata2 = v2 ? ram2 : 32'd0;

endmodule

/* sv/rvxu_exec.sv */
// Execute logic: ALU, branch resolution, next pc and memory request.
module rvxu_exec (
  input  rvxu_pkg::cmd_t      command,
  input  logic [4:0]          rd,
  input  logic [4:0]          shamt,
  input  logic [31:0]         imm,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  input  logic [31:0]         pc,
  output rvxu_pkg::exec_res_t res,
  output rvxu_pkg::mem_req_t  req
);

  logic [31:0]        sum;
  logic [31:0]        pc4;
  logic [31:0]        pcimm;
  logic               slt;
  logic               ult;
  logic               cond;
  logic               wr;
  logic [31:0]        val;
  logic [31:0]        npc;
  logic               taken;
  rvxu_pkg::ld_kind_t ld;
  logic               st_b;
  logic               st_w;

  assign sum   = a + imm;
  assign pc4   = pc + 32'd4;
  assign pcimm = pc + imm;
  assign slt   = $signed(a) < $signed(b);
  assign ult   = a < b;

  // Decode and evaluate one instruction
  always_comb begin
    npc   = pc4;
    taken = 1'b0;
    wr    = 1'b0;
    val   = 32'd0;
    ld    = rvxu_pkg::LD_NONE;
    cond  = 1'b0;
    st_b  = 1'b0;
    st_w  = 1'b0;
    case (command)
      rvxu_pkg::CMD_ADD:   begin val = a + b;   wr = 1'b1; end
      rvxu_pkg::CMD_AND:   begin val = a & b;   wr = 1'b1; end
      rvxu_pkg::CMD_OR:    begin val = a | b;   wr = 1'b1; end
      rvxu_pkg::CMD_SUB:   begin val = a - b;   wr = 1'b1; end
      rvxu_pkg::CMD_XOR:   begin val = a ^ b;   wr = 1'b1; end
      rvxu_pkg::CMD_ADDI:  begin val = sum;     wr = 1'b1; end
      rvxu_pkg::CMD_ANDI:  begin val = a & imm; wr = 1'b1; end
      rvxu_pkg::CMD_ORI:   begin val = a | imm; wr = 1'b1; end
      rvxu_pkg::CMD_AUIPC: begin val = pcimm;   wr = 1'b1; end
      rvxu_pkg::CMD_LUI:   begin val = imm;     wr = 1'b1; end
      rvxu_pkg::CMD_BEQ:   cond = (a == b);
      rvxu_pkg::CMD_BNE:   cond = (a != b);
      rvxu_pkg::CMD_BGE:   cond = !slt;
      rvxu_pkg::CMD_BGEU:  cond = !ult;
      rvxu_pkg::CMD_BLT:   cond = slt;
      rvxu_pkg::CMD_BLTU:  cond = ult;
      rvxu_pkg::CMD_JAL: begin
        val   = pc4;
        wr    = 1'b1;
        npc   = pcimm;
        taken = 1'b1;
      end
      rvxu_pkg::CMD_JALR: begin
        val   = pc4;
        wr    = 1'b1;
        npc   = sum & 32'hFFFF_FFFE;
        taken = 1'b1;
      end
      rvxu_pkg::CMD_LB:    begin ld = rvxu_pkg::LD_B;  wr = 1'b1; end
      rvxu_pkg::CMD_LBU:   begin ld = rvxu_pkg::LD_BU; wr = 1'b1; end
      rvxu_pkg::CMD_LW:    begin ld = rvxu_pkg::LD_W;  wr = 1'b1; end
      rvxu_pkg::CMD_SB:    st_b = 1'b1;
      rvxu_pkg::CMD_SW:    st_w = 1'b1;
      rvxu_pkg::CMD_SLTU:  begin val = {31'd0, ult}; wr = 1'b1; end
      rvxu_pkg::CMD_SLT:   begin val = {31'd0, slt}; wr = 1'b1; end
      rvxu_pkg::CMD_SLLI:  begin val = a << shamt; wr = 1'b1; end
      rvxu_pkg::CMD_SRLI:  begin val = a >> shamt; wr = 1'b1; end
      rvxu_pkg::CMD_SRAI:  begin val = $unsigned($signed(a) >>> shamt); wr = 1'b1; end
      default: ;
    endcase
    // Taken branch redirects to pc + imm
    if (cond) begin
      npc   = pcimm;
      taken = 1'b1;
    end
    // Drop writes to x0
    if (rd == 5'd0) begin
      wr = 1'b0;
    end
  end

  assign res.npc   = npc;
  assign res.taken = taken;
  assign res.wr    = wr;
  assign res.rd    = wr ? rd : 5'd0;
  assign res.val   = wr ? val : 32'd0;
  assign res.ld    = ld;

  assign req.st_byte = st_b;
  assign req.st_word = st_w;
  assign req.addr    = sum[rvxu_pkg::BADDR_W-1:0];
  assign req.data    = b;

endmodule

/* sv/rvxu_dmem.sv */
// Data memory: four byte lanes with wrapped word access and a clearing pass after reset.
module rvxu_dmem (
  input  logic               clk,
  input  logic               rst,
  input  logic               re,
  input  logic               issue,
  input  rvxu_pkg::mem_req_t req,
  output logic [31:0]        ld_word,
  output logic               clearing
);

  logic [rvxu_pkg::ROW_W-1:0] clr_cnt;
  logic [1:0]                 lo;
  logic [1:0]                 lo_q;
  logic [rvxu_pkg::ROW_W-1:0] row0;
  logic [rvxu_pkg::ROW_W-1:0] row1;
  logic [rvxu_pkg::ROW_W-1:0] lane_row [4];
  logic [7:0]                 lane_q   [4];

  assign lo   = req.addr[1:0];
  assign row0 = req.addr[rvxu_pkg::BADDR_W-1:2];
  assign row1 = row0 + rvxu_pkg::ROW_W'(1);

  // Sweep every row to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + rvxu_pkg::ROW_W'(1);
      if (clr_cnt == rvxu_pkg::ROW_W'(rvxu_pkg::MEM_ROWS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Hold the byte offset of the pending read
  always_ff @(posedge clk) begin
    if (re) begin
      lo_q <= lo;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [1:0]                 bsel;
    logic                       lwe;
    logic [7:0]                 lwdata;
    logic [rvxu_pkg::ROW_W-1:0] lwaddr;

    // Lanes below the start offset belong to the next row
    assign lane_row[k] = (2'(k) < lo) ? row1 : row0;
    assign bsel        = 2'(k) - lo;

    // Steer store bytes, or zeros during the clearing pass
    always_comb begin
      if (clearing) begin
        lwe    = 1'b1;
        lwaddr = clr_cnt;
        lwdata = 8'd0;
      end else begin
        lwe    = issue && (req.st_word || (req.st_byte && lo == 2'(k)));
        lwaddr = lane_row[k];
        lwdata = req.data[{bsel, 3'b000} +: 8];
      end
    end

    rvxu_ram #(.WIDTH(8), .DEPTH(rvxu_pkg::MEM_ROWS)) u_lane (
      .clk   (clk),
      .we    (lwe),
      .waddr (lwaddr),
      .wdata (lwdata),
      .re    (re),
      .raddr (lane_row[k]),
      .rdata (lane_q[k])
    );
  end

  // Rotate lane data back into byte order
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ld_word[8*i +: 8] = lane_q[lo_q + 2'(i)];
    end
  end

endmodule

/* sv/rv32_integer_execute_unit.sv */
// Top level: input register, execute, memory access and result register of the RV32 unit.
// Each instruction passes the execute, memory stage and result registers in turn.
// Throughput: one instruction per cycle unless stalled, even dependent back-to-back ones.
// Reset clears the pc and register file at once; the data memory is then cleared
// one row per cycle over all MEM_BYTES/4 rows (4096), during which cmd_stall stays high.
// A stalled result stops the pipeline only once its empty stages have filled.
module rv32_integer_execute_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [4:0]         command,
  input  logic [4:0]         dest_reg,
  input  logic [4:0]         src1_reg,
  input  logic [4:0]         src2_reg,
  input  logic signed [31:0] immediate,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [31:0]        next_pc,
  output logic               reg_write,
  output logic [4:0]         write_index,
  output logic [31:0]        write_value,
  output logic               branch_taken
);

  // Pipeline control
  logic s1_valid;
  logic s2_valid;
  logic out_free;
  logic s2_free;
  logic s1_free;
  logic s1_move;
  logic s2_move;
  logic accept;
  logic clearing;

  // Execute stage registers
  rvxu_pkg::cmd_t s1_cmd;
  logic [4:0]     s1_rd;
  logic [4:0]     s1_r1;
  logic [4:0]     s1_r2;
  logic [31:0]    s1_imm;
  logic [31:0]    pc;

  // Memory stage registers
  rvxu_pkg::exec_res_t s2;

  // Last register file write, for bypass into execute
  logic        last_wr;
  logic [4:0]  last_rd;
  logic [31:0] last_val;

  logic [31:0]         rf_a;
  logic [31:0]         rf_b;
  logic [31:0]         op_a;
  logic [31:0]         op_b;
  rvxu_pkg::exec_res_t ex_res;
  rvxu_pkg::mem_req_t  ex_req;
  logic [31:0]         ld_word;
  logic [31:0]         ld_val;
  logic [31:0]         s2_result;
  logic                rf_we;

  assign out_free  = !res_valid || !res_stall;
  assign s2_free   = !s2_valid || out_free;
  assign s1_free   = !s1_valid || s2_free;
  assign s1_move   = s1_valid && s2_free;
  assign s2_move   = s2_valid && out_free;
  assign cmd_stall = clearing || !s1_free;
  assign accept    = cmd_valid && !cmd_stall;
  assign rf_we     = s2_move && s2.wr;

  rvxu_regfile u_regfile (
    .clk    (clk),
    .rst    (rst),
    .re     (s1_free),
    .raddr1 (src1_reg),
    .raddr2 (src2_reg),
    .we     (rf_we),
    .waddr  (s2.rd),
    .wdata  (s2_result),
    .rdata1 (rf_a),
    .rdata2 (rf_b)
  );

  // Bypass: pending memory-stage result first, then the last write
  always_comb begin
    if (s2_valid && s2.wr && s2.rd == s1_r1) begin
      op_a = s2_result;
    end else if (last_wr && last_rd == s1_r1) begin
      op_a = last_val;
    end else begin
      op_a = rf_a;
    end
    if (s2_valid && s2.wr && s2.rd == s1_r2) begin
      op_b = s2_result;
    end else if (last_wr && last_rd == s1_r2) begin
      op_b = last_val;
    end else begin
      op_b = rf_b;
    end
  end

  rvxu_exec u_exec (
    .command (s1_cmd),
    .rd      (s1_rd),
    .shamt   (s1_r2),
    .imm     (s1_imm),
    .a       (op_a),
    .b       (op_b),
    .pc      (pc),
    .res     (ex_res),
    .req     (ex_req)
  );

  rvxu_dmem u_dmem (
    .clk      (clk),
    .rst      (rst),
    .re       (s2_free),
    .issue    (s1_move),
    .req      (ex_req),
    .ld_word  (ld_word),
    .clearing (clearing)
  );

  // Format load data and zero the value when nothing is written
  always_comb begin
    case (s2.ld)
      rvxu_pkg::LD_B:  ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
      rvxu_pkg::LD_BU: ld_val = {24'd0, ld_word[7:0]};
      rvxu_pkg::LD_W:  ld_val = ld_word;
      default:         ld_val = s2.val;
    endcase
    s2_result = s2.wr ? ld_val : 32'd0;
  end

  // Advance valid flags, pc and the write bypass record
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
      pc        <= 32'd0;
      last_wr   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
        pc       <= ex_res.npc;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (rf_we) begin
        last_wr <= 1'b1;
      end
    end
  end

  // Load payload registers on each transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd <= command;
      s1_rd  <= dest_reg;
      s1_r1  <= src1_reg;
      s1_r2  <= src2_reg;
      s1_imm <= $unsigned(immediate);
    end
    if (s1_move) begin
      s2 <= ex_res;
    end
    if (rf_we) begin
      last_rd  <= s2.rd;
      last_val <= s2_result;
    end
    if (s2_move) begin
      next_pc      <= s2.npc;
      reg_write    <= s2.wr;
      write_index  <= s2.rd;
      write_value  <= s2_result;
      branch_taken <= s2.taken;
    end
  end

endmodule

/* dv/rv32_retire_monitor.sv */
// Retire monitor for the RV32 execute unit: predicts each instruction's outcome and checks results.
module rv32_retire_monitor
  import rvxu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  logic        cmd_stall,
  input  logic [4:0]  command,
  input  logic [4:0]  dest_reg,
  input  logic [4:0]  src1_reg,
  input  logic [4:0]  src2_reg,
  input  logic [31:0] immediate,
  input  logic        res_valid,
  input  logic        res_stall,
  input  logic [31:0] next_pc,
  input  logic        reg_write,
  input  logic [4:0]  write_index,
  input  logic [31:0] write_value,
  input  logic        branch_taken,
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic [31:0] npc;
    logic        wr;
    logic [4:0]  idx;
    logic [31:0] val;
    logic        taken;
  } retire_t;

  // Architectural state mirrored from the block
  logic [31:0] gpr [32];
  logic [31:0] pc;
  logic [7:0]  dmem [MEM_BYTES];

  retire_t pending_retire [$];
  int      mismatches = 0;

  // Byte addresses wrap modulo the memory size
  function automatic logic [BADDR_W-1:0] byte_slot(logic [31:0] addr);
    return addr[BADDR_W-1:0];
  endfunction

  // Execute one instruction against the mirrored state and return its outcome
  function automatic retire_t execute_insn(cmd_t op, logic [4:0] rd, logic [4:0] rs1,
                                           logic [4:0] rs2, logic [31:0] imm);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] ea;
    logic [31:0] npc;
    logic [31:0] val;
    logic        wr;
    logic        taken;
    retire_t     r;
    a     = gpr[rs1];
    b     = gpr[rs2];
    ea    = a + imm;
    npc   = pc + 32'd4;
    val   = '0;
    wr    = 1'b0;
    taken = 1'b0;
    case (op)
      CMD_ADD:   begin val = a + b; wr = 1'b1; end
      CMD_AND:   begin val = a & b; wr = 1'b1; end
      CMD_OR:    begin val = a | b; wr = 1'b1; end
      CMD_SUB:   begin val = a - b; wr = 1'b1; end
      CMD_XOR:   begin val = a ^ b; wr = 1'b1; end
      CMD_ADDI:  begin val = a + imm; wr = 1'b1; end
      CMD_ANDI:  begin val = a & imm; wr = 1'b1; end
      CMD_ORI:   begin val = a | imm; wr = 1'b1; end
      CMD_AUIPC: begin val = pc + imm; wr = 1'b1; end
      CMD_LUI:   begin val = imm; wr = 1'b1; end
      CMD_BEQ:   taken = (a == b);
      CMD_BNE:   taken = (a != b);
      CMD_BGE:   taken = ($signed(a) >= $signed(b));
      CMD_BGEU:  taken = (a >= b);
      CMD_BLT:   taken = ($signed(a) < $signed(b));
      CMD_BLTU:  taken = (a < b);
      CMD_JAL:   begin val = pc + 32'd4; wr = 1'b1; taken = 1'b1; end
      CMD_JALR:  begin val = pc + 32'd4; wr = 1'b1; taken = 1'b1; end
      CMD_LB: begin
        val = {{24{dmem[byte_slot(ea)][7]}}, dmem[byte_slot(ea)]};
        wr  = 1'b1;
      end
      CMD_LBU:   begin val = {24'd0, dmem[byte_slot(ea)]}; wr = 1'b1; end
      CMD_LW: begin
        // little-endian, each byte wraps on its own
        val = {dmem[byte_slot(ea + 32'd3)], dmem[byte_slot(ea + 32'd2)],
               dmem[byte_slot(ea + 32'd1)], dmem[byte_slot(ea)]};
        wr  = 1'b1;
      end
      CMD_SB:    dmem[byte_slot(ea)] = b[7:0];
      CMD_SW: begin
        dmem[byte_slot(ea)]          = b[7:0];
        dmem[byte_slot(ea + 32'd1)]  = b[15:8];
        dmem[byte_slot(ea + 32'd2)]  = b[23:16];
        dmem[byte_slot(ea + 32'd3)]  = b[31:24];
      end
      CMD_SLTU:  begin val = {31'd0, a < b}; wr = 1'b1; end
      CMD_SLT:   begin val = {31'd0, $signed(a) < $signed(b)}; wr = 1'b1; end
      CMD_SLLI:  begin val = a << rs2; wr = 1'b1; end
      CMD_SRLI:  begin val = a >> rs2; wr = 1'b1; end
      CMD_SRAI:  begin val = $signed(a) >>> rs2; wr = 1'b1; end
      default: ;
    endcase
    // jalr target uses the base read before the link write, bit 0 cleared
    if (op == CMD_JALR)
      npc = ea & 32'hFFFF_FFFE;
    else if (taken)
      npc = pc + imm;
    // drop writes to x0
    if (rd == 5'd0)
      wr = 1'b0;
    if (wr) begin
      gpr[rd] = val;
    end else begin
      val = '0;
      rd  = '0;
    end
    pc = npc;
    r = '{npc: npc, wr: wr, idx: rd, val: val, taken: taken};
    return r;
  endfunction

  // Check retired results in order, then record the newly accepted instruction
  always @(posedge clk) begin
    retire_t got;
    retire_t want;
    if (rst) begin
      for (int i = 0; i < 32; i++)
        gpr[i] = '0;
      for (int i = 0; i < MEM_BYTES; i++)
        dmem[i] = '0;
      pc = '0;
      pending_retire.delete();
    end else begin
      if (res_valid && !res_stall) begin
        got = '{npc: next_pc, wr: reg_write, idx: write_index, val: write_value,
                taken: branch_taken};
        if (pending_retire.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: pc=%h wr=%0d rd=%0d val=%h br=%0d",
                     got.npc, got.wr, got.idx, got.val, got.taken);
        end else begin
          want = pending_retire.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected pc=%h wr=%0d rd=%0d val=%h br=%0d,",
                        " got pc=%h wr=%0d rd=%0d val=%h br=%0d"},
                       want.npc, want.wr, want.idx, want.val, want.taken,
                       got.npc, got.wr, got.idx, got.val, got.taken);
          end
        end
      end
      if (cmd_valid && !cmd_stall)
        pending_retire.push_back(execute_insn(command, dest_reg, src1_reg, src2_reg,
                                              immediate));
    end
    outstanding <= pending_retire.size();
    errors      <= mismatches;
  end

endmodule

/* dv/tb_rv32_integer_execute_unit.sv */
// Testbench top for the RV32 execute unit: clock, reset, instruction stream, result stalls, verdict.
module tb_rv32_integer_execute_unit;
  import rvxu_pkg::*;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               cmd_valid    = 1'b0;
  logic               cmd_stall;
  logic [4:0]         command      = '0;
  logic [4:0]         dest_reg     = '0;
  logic [4:0]         src1_reg     = '0;
  logic [4:0]         src2_reg     = '0;
  logic signed [31:0] immediate    = '0;
  logic               res_valid;
  logic               res_stall    = 1'b0;
  logic [31:0]        next_pc;
  logic               reg_write;
  logic [4:0]         write_index;
  logic [31:0]        write_value;
  logic               branch_taken;

  int errors;
  int outstanding;
  int retired   = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rv32_integer_execute_unit uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .command(command), .dest_reg(dest_reg), .src1_reg(src1_reg), .src2_reg(src2_reg),
    .immediate(immediate),
    .res_valid(res_valid), .res_stall(res_stall),
    .next_pc(next_pc), .reg_write(reg_write), .write_index(write_index),
    .write_value(write_value), .branch_taken(branch_taken)
  );

  rv32_retire_monitor retire_mon (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .command(command), .dest_reg(dest_reg), .src1_reg(src1_reg), .src2_reg(src2_reg),
    .immediate(immediate),
    .res_valid(res_valid), .res_stall(res_stall),
    .next_pc(next_pc), .reg_write(reg_write), .write_index(write_index),
    .write_value(write_value), .branch_taken(branch_taken),
    .errors(errors), .outstanding(outstanding)
  );

  // Count result transfers to time the long receiver hold
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      retired <= retired + 1;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one instruction, hold it until transfer, then sometimes idle a while
  task automatic issue(cmd_t op, logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2,
                       logic [31:0] imm);
    int gap;
    cmd_valid <= 1'b1;
    command   <= op;
    dest_reg  <= rd;
    src1_reg  <= rs1;
    src2_reg  <= rs2;
    immediate <= imm;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    if ($urandom_range(0, 99) == 0)
      send_calm = !send_calm;
    gap = send_calm ? 0 : idle_len();
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Immediates: small values, full-range values and boundary values
  function automatic logic [31:0] pick_imm();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 255) - 128;
    if (r < 70) return $urandom;
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'h0000_0001;
      default: return MEM_BYTES;
    endcase
  endfunction

  // Random instruction, biased so loads hit stored bytes and branches go both ways
  task automatic random_insn();
    int          k;
    cmd_t        op;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    k = $urandom_range(0, 99);
    if (k < 3)
      op = cmd_t'($urandom_range(int'(CMD_SRAI) + 1, 2**$bits(cmd_t) - 1));
    else if (k < 35)
      op = cmd_t'($urandom_range(CMD_LB, CMD_SW));
    else
      op = cmd_t'($urandom_range(CMD_ADD, CMD_SRAI));
    rd  = 5'($urandom);
    rs1 = 5'($urandom);
    rs2 = 5'($urandom);
    imm = pick_imm();
    if (op >= CMD_BEQ && op <= CMD_BLTU && $urandom_range(0, 3) == 0)
      rs2 = rs1;
    // keep most memory traffic in a small window and around the wrap point
    if (op >= CMD_LB && op <= CMD_SW && $urandom_range(0, 9) < 7) begin
      rs1 = 5'd0;
      case ($urandom_range(0, 3))
        2: imm = MEM_BYTES - $urandom_range(1, 4);
        3: imm = 32'd0 - $urandom_range(1, 4);
        default: imm = $urandom_range(0, 63);
      endcase
    end
    issue(op, rd, rs1, rs2, imm);
  endtask

  // Result stall: random gaps plus one long hold so the pipeline backs up
  initial begin
    int n;
    wait (!rst);
    forever begin
      if (!hold_done && retired >= 300) begin
        res_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
        res_stall <= 1'b0;
        @(posedge clk);
      end else begin
        if ($urandom_range(0, 63) == 0)
          recv_calm = !recv_calm;
        n = recv_calm ? 0 : idle_len();
        if (n == 0) begin
          res_stall <= 1'b0;
          @(posedge clk);
        end else begin
          res_stall <= 1'b1;
          repeat (n) @(posedge clk);
          res_stall <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  // Reset, directed instructions, random stream, drain and verdict
  initial begin
    int w;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // operand extremes
    issue(CMD_LUI,  5'd1, 5'd0, 5'd0, 32'h8000_0000);
    issue(CMD_ADDI, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF);
    issue(CMD_ORI,  5'd3, 5'd0, 5'd0, 32'h7FFF_FFFF);
    issue(CMD_ADD,  5'd4, 5'd1, 5'd2, 32'h0);
    issue(CMD_SUB,  5'd5, 5'd1, 5'd3, 32'h0);
    issue(CMD_AND,  5'd6, 5'd2, 5'd3, 32'h0);
    issue(CMD_OR,   5'd7, 5'd1, 5'd3, 32'h0);
    issue(CMD_XOR,  5'd8, 5'd2, 5'd1, 32'h0);
    issue(CMD_ANDI, 5'd9, 5'd2, 5'd0, 32'h0000_0F0F);
    issue(CMD_SLT,  5'd10, 5'd1, 5'd3, 32'h0);
    issue(CMD_SLTU, 5'd11, 5'd1, 5'd3, 32'h0);
    issue(CMD_SLLI, 5'd12, 5'd2, 5'd31, 32'h0);
    issue(CMD_SRLI, 5'd13, 5'd1, 5'd31, 32'h0);
    issue(CMD_SRAI, 5'd14, 5'd1, 5'd31, 32'h0);
    // word store and load straddling the end of memory, byte store and loads, auipc
    issue(CMD_SW,   5'd0, 5'd0, 5'd3, MEM_BYTES - 2);
    issue(CMD_LW,   5'd15, 5'd0, 5'd0, 32'hFFFF_FFFE);
    issue(CMD_SB,   5'd0, 5'd0, 5'd2, 32'd5);
    issue(CMD_LB,   5'd16, 5'd0, 5'd0, 32'd5);
    issue(CMD_LBU,  5'd17, 5'd0, 5'd0, 32'd5);
    issue(CMD_AUIPC, 5'd18, 5'd0, 5'd0, 32'hFFFF_F000);
    // branches taken and not taken, signed against unsigned
    issue(CMD_BEQ,  5'd0, 5'd1, 5'd1, 32'd16);
    issue(CMD_BNE,  5'd0, 5'd1, 5'd1, 32'd16);
    issue(CMD_BGE,  5'd0, 5'd1, 5'd3, 32'd12);
    issue(CMD_BGEU, 5'd0, 5'd1, 5'd3, 32'hFFFF_FFF8);
    issue(CMD_BLT,  5'd0, 5'd1, 5'd3, 32'h7FFF_FFFC);
    issue(CMD_BLTU, 5'd0, 5'd2, 5'd1, 32'd8);
    // jumps, jalr with link into its own base and an odd offset
    issue(CMD_JAL,  5'd19, 5'd0, 5'd0, 32'hFFFF_FFFC);
    issue(CMD_JALR, 5'd2, 5'd2, 5'd0, 32'd3);
    // dropped write to x0, then an unused command
    issue(CMD_XOR,  5'd0, 5'd2, 5'd3, 32'h0);
    issue(cmd_t'(2**$bits(cmd_t) - 1), 5'd5, 5'd1, 5'd2, 32'hFFFF_FFFF);

    repeat (1620) random_insn();
    cmd_valid <= 1'b0;

    // let the monitor count the last transfer before draining
    @(posedge clk);

    // drain outstanding results, then let the pipeline settle
    for (w = 0; w < 200000 && outstanding != 0; w++)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #6_400_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
